@@ hw/rtl/fds_pkg.sv @@
// Shared constants, codes and address helpers for the firmware download sequencer.
package fds_pkg;

    localparam int SECTOR_BYTES = 8192;
    localparam int CHUNK_BYTES  = 128;

    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int CHUNK_SHIFT  = $clog2(CHUNK_BYTES);

    localparam int SIZE_W       = 19;
    localparam int CRC_W        = 32;
    localparam int DELAY_W      = 8;
    localparam int SECTOR_IDX_W = 6;
    localparam int CHUNK_IDX_W  = 12;

    localparam int SEC_END_W = SECTOR_IDX_W + 1 + SECTOR_SHIFT;
    localparam int CHK_END_W = CHUNK_IDX_W + 1 + CHUNK_SHIFT;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd10;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;
    localparam int PADDR_W   = 3;

    // register index taken from paddr[2]
    localparam logic REG_STARTUP_DELAY = 1'b0;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_TICK  = 2'd1,
        EV_DONE  = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        K_AUTOBAUD = 3'd0,
        K_PING     = 3'd1,
        K_ERASE    = 3'd2,
        K_DLSTART  = 3'd3,
        K_DATA     = 3'd4,
        K_CRCQ     = 3'd5,
        K_FINISHED = 3'd6
    } kind_t;

    function automatic logic [SIZE_W-1:0] sector_addr(input logic [SECTOR_IDX_W-1:0] idx);
        logic [SECTOR_IDX_W+SECTOR_SHIFT-1:0] full;
        full = {idx, {SECTOR_SHIFT{1'b0}}};
        return SIZE_W'(full);
    endfunction

    function automatic logic [SIZE_W-1:0] chunk_addr(input logic [CHUNK_IDX_W-1:0] idx);
        logic [CHUNK_IDX_W+CHUNK_SHIFT-1:0] full;
        full = {idx, {CHUNK_SHIFT{1'b0}}};
        return SIZE_W'(full);
    endfunction

endpackage

@@ hw/rtl/firmware_download_sequencer_top.sv @@
// Firmware download sequencer: event decode, command sequencing and output register.
// Latency: a command word appears on m_* the cycle after its event word is accepted.
// Throughput: one event word per cycle; s_tready drops only while a command word
// waits in the output register and m_tready is low.
// Reset (rst_n low, asynchronous): sequencer idle, counters and stored image cleared,
// startup delay register back to 10 ticks, no command word pending.
module firmware_download_sequencer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // event channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fds_pkg::S_TDATA_W-1:0]   s_tdata,   // [18:0] image_size, [50:19] image_crc
    input  logic [1:0]                      s_tuser,   // [1:0] cmd
    // command channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fds_pkg::M_TDATA_W-1:0]   m_tdata,   // [18:0] target_address,
                                                       // [37:19] byte_count, [69:38] crc_word
    output logic [2:0]                      m_tuser,   // [2:0] command_kind
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fds_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DELAY   = 3'd1,
        PH_PING    = 3'd2,
        PH_ERASE   = 3'd3,
        PH_DLSTART = 3'd4,
        PH_DATA    = 3'd5,
        PH_CRC     = 3'd6
    } phase_t;

    // Sequencer state
    phase_t                              phase_reg, phase_next;
    logic [fds_pkg::SIZE_W-1:0]          size_reg, size_next;
    logic [fds_pkg::CRC_W-1:0]           crc_reg, crc_next;
    logic [fds_pkg::SECTOR_IDX_W-1:0]    sector_reg, sector_next;
    logic [fds_pkg::CHUNK_IDX_W-1:0]     chunk_reg, chunk_next;
    logic [fds_pkg::DELAY_W-1:0]         delay_reg, delay_next;
    logic [fds_pkg::DELAY_W-1:0]         startup_reg;

    // Output register
    logic                                out_valid_reg, out_valid_next;
    fds_pkg::kind_t                      out_kind_reg, out_kind_next;
    logic [fds_pkg::SIZE_W-1:0]          out_addr_reg, out_addr_next;
    logic [fds_pkg::SIZE_W-1:0]          out_count_reg, out_count_next;
    logic [fds_pkg::CRC_W-1:0]           out_crc_reg, out_crc_next;

    // Decoded input word
    fds_pkg::event_t                     ev;
    logic [fds_pkg::SIZE_W-1:0]          in_size;
    logic [fds_pkg::CRC_W-1:0]           in_crc;
    logic                                accept;

    // Result of this word
    logic                                res_valid;
    fds_pkg::kind_t                      res_kind;
    logic [fds_pkg::SIZE_W-1:0]          res_addr;
    logic [fds_pkg::SIZE_W-1:0]          res_count;
    logic [fds_pkg::CRC_W-1:0]           res_crc;

    // Last-sector / last-chunk tests and data length
    logic [fds_pkg::SECTOR_IDX_W:0]      sector_inc;
    logic [fds_pkg::CHUNK_IDX_W:0]       chunk_inc;
    logic [fds_pkg::SEC_END_W-1:0]       sector_end;
    logic [fds_pkg::CHK_END_W-1:0]       chunk_end;
    logic                                last_sector;
    logic                                last_chunk;
    logic [fds_pkg::CHUNK_IDX_W-1:0]     data_idx;
    logic [fds_pkg::SIZE_W-1:0]          data_addr;
    logic [fds_pkg::SIZE_W-1:0]          data_rest;
    logic [fds_pkg::SIZE_W-1:0]          data_len;

    logic                                cfg_write;

    assign ev      = fds_pkg::event_t'(s_tuser);
    assign in_size = s_tdata[fds_pkg::SIZE_W-1:0];
    assign in_crc  = s_tdata[fds_pkg::SIZE_W +: fds_pkg::CRC_W];

    // The output register frees itself when the downstream takes the word.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(fds_pkg::M_TDATA_W - 2*fds_pkg::SIZE_W - fds_pkg::CRC_W){1'b0}},
                       out_crc_reg, out_count_reg, out_addr_reg};

    // APB: always ready, one register at index 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == fds_pkg::REG_STARTUP_DELAY);
    assign prdata    = (paddr[2] == fds_pkg::REG_STARTUP_DELAY)
                     ? {{(32-fds_pkg::DELAY_W){1'b0}}, startup_reg} : 32'd0;

    // A sector or chunk is the last one once its end reaches the image size.
    assign sector_inc  = {1'b0, sector_reg} + 1'b1;
    assign chunk_inc   = {1'b0, chunk_reg} + 1'b1;
    assign sector_end  = {sector_inc, {fds_pkg::SECTOR_SHIFT{1'b0}}};
    assign chunk_end   = {chunk_inc, {fds_pkg::CHUNK_SHIFT{1'b0}}};
    assign last_sector = sector_end >= fds_pkg::SEC_END_W'(size_reg);
    assign last_chunk  = chunk_end >= fds_pkg::CHK_END_W'(size_reg);

    // Data word: first chunk out of download-start, else the next chunk.
    assign data_idx  = (phase_reg == PH_DATA) ? chunk_inc[fds_pkg::CHUNK_IDX_W-1:0]
                                              : '0;
    assign data_addr = fds_pkg::chunk_addr(data_idx);
    assign data_rest = (size_reg > data_addr) ? (size_reg - data_addr) : '0;
    assign data_len  = (data_rest > fds_pkg::SIZE_W'(fds_pkg::CHUNK_BYTES))
                     ? fds_pkg::SIZE_W'(fds_pkg::CHUNK_BYTES) : data_rest;

    always_comb
    begin
        phase_next  = phase_reg;
        size_next   = size_reg;
        crc_next    = crc_reg;
        sector_next = sector_reg;
        chunk_next  = chunk_reg;
        delay_next  = delay_reg;

        res_valid = 1'b0;
        res_kind  = fds_pkg::K_AUTOBAUD;
        res_addr  = '0;
        res_count = '0;
        res_crc   = '0;

        if (accept)
        begin
            unique case (ev)
                fds_pkg::EV_START:
                begin
                    // restarts even mid-sequence
                    size_next   = in_size;
                    crc_next    = in_crc;
                    sector_next = '0;
                    chunk_next  = '0;
                    delay_next  = '0;
                    phase_next  = PH_DELAY;
                    res_valid   = 1'b1;
                    res_kind    = fds_pkg::K_AUTOBAUD;
                end
                fds_pkg::EV_TICK:
                begin
                    if (phase_reg == PH_DELAY)
                    begin
                        if (delay_reg >= startup_reg)
                        begin
                            phase_next = PH_PING;
                            res_valid  = 1'b1;
                            res_kind   = fds_pkg::K_PING;
                        end
                        else
                        begin
                            delay_next = delay_reg + 1'b1;
                        end
                    end
                end
                fds_pkg::EV_DONE:
                begin
                    unique case (phase_reg)
                        PH_PING:
                        begin
                            sector_next = '0;
                            res_valid   = 1'b1;
                            if (size_reg == '0)
                            begin
                                phase_next = PH_DLSTART;
                                res_kind   = fds_pkg::K_DLSTART;
                                res_count  = size_reg;
                                res_crc    = crc_reg;
                            end
                            else
                            begin
                                phase_next = PH_ERASE;
                                res_kind   = fds_pkg::K_ERASE;
                            end
                        end
                        PH_ERASE:
                        begin
                            res_valid = 1'b1;
                            if (last_sector)
                            begin
                                phase_next = PH_DLSTART;
                                res_kind   = fds_pkg::K_DLSTART;
                                res_count  = size_reg;
                                res_crc    = crc_reg;
                            end
                            else
                            begin
                                sector_next = sector_inc[fds_pkg::SECTOR_IDX_W-1:0];
                                res_kind    = fds_pkg::K_ERASE;
                                res_addr    = fds_pkg::sector_addr(
                                                  sector_inc[fds_pkg::SECTOR_IDX_W-1:0]);
                            end
                        end
                        PH_DLSTART:
                        begin
                            chunk_next = '0;
                            res_valid  = 1'b1;
                            if (size_reg == '0)
                            begin
                                phase_next = PH_CRC;
                                res_kind   = fds_pkg::K_CRCQ;
                                res_count  = size_reg;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                                res_kind   = fds_pkg::K_DATA;
                                res_addr   = data_addr;
                                res_count  = data_len;
                            end
                        end
                        PH_DATA:
                        begin
                            res_valid = 1'b1;
                            if (last_chunk)
                            begin
                                phase_next = PH_CRC;
                                res_kind   = fds_pkg::K_CRCQ;
                                res_count  = size_reg;
                            end
                            else
                            begin
                                chunk_next = data_idx;
                                res_kind   = fds_pkg::K_DATA;
                                res_addr   = data_addr;
                                res_count  = data_len;
                            end
                        end
                        PH_CRC:
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_kind   = fds_pkg::K_FINISHED;
                        end
                        default:
                        begin
                            // idle or delay: response ignored
                        end
                    endcase
                end
                default:
                begin
                    // unused event code
                end
            endcase
        end

        // output register: load on a result, drain when taken
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_count_next = out_count_reg;
        out_crc_next   = out_crc_reg;
        if (accept && res_valid)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind;
            out_addr_next  = res_addr;
            out_count_next = res_count;
            out_crc_next   = res_crc;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            size_reg      <= '0;
            crc_reg       <= '0;
            sector_reg    <= '0;
            chunk_reg     <= '0;
            delay_reg     <= '0;
            startup_reg   <= fds_pkg::DELAY_RESET;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= fds_pkg::K_AUTOBAUD;
            out_addr_reg  <= '0;
            out_count_reg <= '0;
            out_crc_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            size_reg      <= size_next;
            crc_reg       <= crc_next;
            sector_reg    <= sector_next;
            chunk_reg     <= chunk_next;
            delay_reg     <= delay_next;
            if (cfg_write)
            begin
                startup_reg <= pwdata[fds_pkg::DELAY_W-1:0];
            end
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_addr_reg  <= out_addr_next;
            out_count_reg <= out_count_next;
            out_crc_reg   <= out_crc_next;
        end
    end

endmodule

@@ test/fds_command_checker.sv @@
`timescale 1ns / 1ps
// Command checker for the firmware download sequencer: tracks the sequence and compares words.
module fds_command_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fds_pkg::S_TDATA_W-1:0]   s_tdata,   // [18:0] image_size, [50:19] image_crc
    input  logic [1:0]                      s_tuser,   // [1:0] cmd
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fds_pkg::M_TDATA_W-1:0]   m_tdata,   // [18:0] target_address,
                                                       // [37:19] byte_count, [69:38] crc_word
    input  logic [2:0]                      m_tuser,   // [2:0] command_kind
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fds_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    input  logic [31:0]                     prdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              cmds_pending
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELAY,
        ST_PING,
        ST_ERASE,
        ST_DLSTART,
        ST_DATA,
        ST_CRC
    } seq_state_t;

    typedef struct packed {
        fds_pkg::kind_t                 kind;
        logic [fds_pkg::SIZE_W-1:0]     addr;
        logic [fds_pkg::SIZE_W-1:0]     count;
        logic [fds_pkg::CRC_W-1:0]      crc;
    } cmd_word_t;

    seq_state_t                             state;
    logic [fds_pkg::SIZE_W-1:0]             img_size;
    logic [fds_pkg::CRC_W-1:0]              img_crc;
    logic [fds_pkg::SECTOR_IDX_W-1:0]       sec_idx;
    logic [fds_pkg::CHUNK_IDX_W-1:0]        chk_idx;
    logic [fds_pkg::DELAY_W-1:0]            tick_cnt;
    logic [fds_pkg::DELAY_W-1:0]            delay_cfg;
    cmd_word_t                              expected_cmds[$];

    function automatic cmd_word_t cmd_word(input fds_pkg::kind_t kind, input int addr,
                                           input int count,
                                           input logic [fds_pkg::CRC_W-1:0] crc);
        cmd_word_t w;
        w.kind  = kind;
        w.addr  = fds_pkg::SIZE_W'(addr);
        w.count = fds_pkg::SIZE_W'(count);
        w.crc   = crc;
        return w;
    endfunction

    function automatic string word_text(input cmd_word_t w);
        return $sformatf("kind=%0d addr=%0h count=%0d crc=%08h",
                         w.kind, w.addr, w.count, w.crc);
    endfunction

    function automatic cmd_word_t dlstart_word();
        state = ST_DLSTART;
        return cmd_word(fds_pkg::K_DLSTART, 0, int'(img_size), img_crc);
    endfunction

    function automatic cmd_word_t crcq_word();
        state = ST_CRC;
        return cmd_word(fds_pkg::K_CRCQ, 0, int'(img_size), '0);
    endfunction

    // last chunk is clipped to what is left of the image
    function automatic cmd_word_t data_word();
        int addr;
        int rest;
        addr = int'(chk_idx) * fds_pkg::CHUNK_BYTES;
        rest = (int'(img_size) > addr) ? int'(img_size) - addr : 0;
        return cmd_word(fds_pkg::K_DATA, addr,
                        (rest > fds_pkg::CHUNK_BYTES) ? fds_pkg::CHUNK_BYTES : rest, '0);
    endfunction

    // advance the sequence by one event word; returns 1 when a command word follows
    function automatic bit next_command(input logic [1:0] code,
                                        input logic [fds_pkg::SIZE_W-1:0] size,
                                        input logic [fds_pkg::CRC_W-1:0] crc,
                                        output cmd_word_t w);
        w = cmd_word(fds_pkg::K_AUTOBAUD, 0, 0, '0);
        case (code)
            fds_pkg::EV_START:
            begin
                img_size = size;
                img_crc  = crc;
                sec_idx  = '0;
                chk_idx  = '0;
                tick_cnt = '0;
                state    = ST_DELAY;
                return 1'b1;
            end
            fds_pkg::EV_TICK:
            begin
                if (state != ST_DELAY)
                    return 1'b0;
                if (tick_cnt >= delay_cfg)
                begin
                    state = ST_PING;
                    w = cmd_word(fds_pkg::K_PING, 0, 0, '0);
                    return 1'b1;
                end
                tick_cnt++;
                return 1'b0;
            end
            fds_pkg::EV_DONE:
            begin
                case (state)
                    ST_PING:
                    begin
                        sec_idx = '0;
                        if (img_size == '0)
                        begin
                            w = dlstart_word();
                            return 1'b1;
                        end
                        state = ST_ERASE;
                        w = cmd_word(fds_pkg::K_ERASE, 0, 0, '0);
                        return 1'b1;
                    end
                    ST_ERASE:
                    begin
                        if ((int'(sec_idx) + 1) * fds_pkg::SECTOR_BYTES >= int'(img_size))
                        begin
                            w = dlstart_word();
                            return 1'b1;
                        end
                        sec_idx++;
                        w = cmd_word(fds_pkg::K_ERASE, int'(sec_idx) * fds_pkg::SECTOR_BYTES,
                                     0, '0);
                        return 1'b1;
                    end
                    ST_DLSTART:
                    begin
                        chk_idx = '0;
                        if (img_size == '0)
                        begin
                            w = crcq_word();
                            return 1'b1;
                        end
                        state = ST_DATA;
                        w = data_word();
                        return 1'b1;
                    end
                    ST_DATA:
                    begin
                        if ((int'(chk_idx) + 1) * fds_pkg::CHUNK_BYTES >= int'(img_size))
                        begin
                            w = crcq_word();
                            return 1'b1;
                        end
                        chk_idx++;
                        w = data_word();
                        return 1'b1;
                    end
                    ST_CRC:
                    begin
                        state = ST_IDLE;
                        w = cmd_word(fds_pkg::K_FINISHED, 0, 0, '0);
                        return 1'b1;
                    end
                    default:
                        return 1'b0;
                endcase
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        cmd_word_t want;
        cmd_word_t got;
        if (!rst_n)
        begin
            state     = ST_IDLE;
            img_size  = '0;
            img_crc   = '0;
            sec_idx   = '0;
            chk_idx   = '0;
            tick_cnt  = '0;
            delay_cfg = fds_pkg::DELAY_RESET;
            expected_cmds.delete();
            mismatches   = 0;
            cmds_pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind  = fds_pkg::kind_t'(m_tuser);
                got.addr  = m_tdata[18:0];
                got.count = m_tdata[37:19];
                got.crc   = m_tdata[69:38];
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected command word, expected none, actual %s",
                             $time, word_text(got));
                    mismatches++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got.kind !== want.kind || got.addr !== want.addr ||
                        got.count !== want.count || got.crc !== want.crc)
                    begin
                        $display("%0t: command mismatch, expected %s, actual %s",
                                 $time, word_text(want), word_text(got));
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (next_command(s_tuser, s_tdata[18:0], s_tdata[50:19], want))
                    expected_cmds.push_back(want);
            end

            if (psel && penable && pready && paddr[2] == fds_pkg::REG_STARTUP_DELAY)
            begin
                if (pwrite)
                    delay_cfg = pwdata[fds_pkg::DELAY_W-1:0];
                else if (prdata !== 32'(delay_cfg))
                begin
                    $display("%0t: startup delay read mismatch, expected %08h actual %08h",
                             $time, 32'(delay_cfg), prdata);
                    mismatches++;
                end
            end

            cmds_pending = expected_cmds.size();
        end
    end

endmodule

@@ test/tb_firmware_download_sequencer_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the firmware download sequencer: event stimulus, config writes, verdict.
module tb_firmware_download_sequencer_top;

    // cmd code the block has no use for; it must be dropped silently
    localparam logic [1:0] EV_UNUSED = 2'd3;

    localparam int ITEM_TARGET    = 950;
    localparam int SETTLE_CYCLES  = 4;     // settling margin once no command word is pending
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake of any kind

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [fds_pkg::S_TDATA_W-1:0]      s_tdata;   // [18:0] image_size, [50:19] image_crc
    logic [1:0]                         s_tuser;   // [1:0] cmd
    logic                               m_tvalid;
    logic                               m_tready;
    logic [fds_pkg::M_TDATA_W-1:0]      m_tdata;   // [18:0] target_address,
                                                   // [37:19] byte_count, [69:38] crc_word
    logic [2:0]                         m_tuser;   // [2:0] command_kind
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [fds_pkg::PADDR_W-1:0]        paddr;
    logic [31:0]                        pwdata;
    logic [31:0]                        prdata;
    logic                               pready;

    int mismatches;
    int cmds_pending;
    int sent_words  = 0;
    int idle_cycles = 0;
    int delay_ticks = int'(fds_pkg::DELAY_RESET);  // what the startup delay register holds now
    bit steady      = 1'b0;                        // no gaps and no stalls on either side

    firmware_download_sequencer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fds_command_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .cmds_pending (cmds_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: any accepted word or APB access counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("firmware_download_sequencer_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Command sink: always ready when steady; else mostly short ready bursts, short stalls, now and then a long stall.
    initial
    begin
        int r;
        int len;
        logic rdy;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (steady)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rdy = 1'b1;
                    len = $urandom_range(1, 8);
                end
                else if (r < 95)
                begin
                    rdy = 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    rdy = 1'b0;
                    len = $urandom_range(10, 40);
                end
                repeat (len)
                begin
                    @(negedge clk);
                    m_tready <= rdy;
                end
            end
        end
    end

    // One event word. A gap, when taken, drops tvalid first; otherwise tvalid stays high
    // and only the payload changes, so tvalid sees one assignment per step.
    task automatic send_word(input logic [1:0] code, input logic [fds_pkg::SIZE_W-1:0] size,
                             input logic [fds_pkg::CRC_W-1:0] crc);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 30);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= fds_pkg::S_TDATA_W'({crc, size});
        do
            @(posedge clk);
        while (!s_tready);
        sent_words++;
    endtask

    // size and CRC only matter on start, so other events carry random payload
    task automatic send_event(input logic [1:0] code);
        send_word(code, fds_pkg::SIZE_W'($urandom), $urandom);
    endtask

    // Drop tvalid and hold off until every predicted command word has come out.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cmds_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the access edge.
    task automatic apb_access(input logic wr, input logic [31:0] wdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {fds_pkg::REG_STARTUP_DELAY, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Only called with the sequencer drained; upper bits are junk the block must drop.
    // The read-back is compared by the checker.
    task automatic set_startup_delay(input logic [fds_pkg::DELAY_W-1:0] ticks);
        wait_drained();
        apb_access(1'b1, {24'($urandom), ticks});
        apb_access(1'b0, '0);
        delay_ticks = int'(ticks);
    endtask

    // Mostly small images; a few up to the full 19-bit range. Those get cut short
    // by the next start since a full run would take thousands of words.
    function automatic logic [fds_pkg::SIZE_W-1:0] pick_image_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 40)
            return fds_pkg::SIZE_W'($urandom_range(1, 512));
        if (r < 70)
            return fds_pkg::SIZE_W'($urandom_range(513, 4096));
        if (r < 90)
            return fds_pkg::SIZE_W'($urandom_range(4097, 3 * fds_pkg::SECTOR_BYTES));
        return fds_pkg::SIZE_W'($urandom);
    endfunction

    // One download: start, delay ticks, then one response-done per command.
    // Some runs stop early, so the next start lands while the sequencer is busy.
    task automatic run_download(input logic [fds_pkg::SIZE_W-1:0] size,
                                input logic [fds_pkg::CRC_W-1:0] crc);
        int n_tick;
        int n_done;
        int stop;
        int k;
        int r;
        logic [1:0] noise;
        n_tick = delay_ticks + 1;
        // erases + download start + data commands + crc query + finished
        n_done = (int'(size) + fds_pkg::SECTOR_BYTES - 1) / fds_pkg::SECTOR_BYTES
               + (int'(size) + fds_pkg::CHUNK_BYTES - 1) / fds_pkg::CHUNK_BYTES + 3;
        stop = n_tick + n_done;
        if (n_done > 300 || $urandom_range(0, 9) == 0)
            stop = $urandom_range(1, (stop > 60) ? 60 : stop - 1);
        send_word(fds_pkg::EV_START, size, crc);
        for (k = 0; k < stop && sent_words < ITEM_TARGET; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                wait_drained();
            else if (r < 9)
            begin
                // noise the sequencer has to ignore in the phase it is in
                if (k < n_tick)
                    noise = ($urandom_range(0, 1) != 0) ? fds_pkg::EV_DONE : EV_UNUSED;
                else
                    noise = ($urandom_range(0, 1) != 0) ? fds_pkg::EV_TICK : EV_UNUSED;
                send_event(noise);
            end
            if (k < n_tick)
                send_event(fds_pkg::EV_TICK);
            else
                send_event(fds_pkg::EV_DONE);
        end
    endtask

    initial
    begin
        int phase_no;
        int n_seq;
        int seq;
        logic [fds_pkg::DELAY_W-1:0] cfg;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // reset value of the startup delay, read back
        apb_access(1'b0, '0);
        // events in idle: all dropped
        send_word(fds_pkg::EV_TICK, '1, '1);
        send_event(fds_pkg::EV_DONE);
        send_event(EV_UNUSED);

        set_startup_delay(8'd1);
        // empty image: ping, then download start and crc query with no erase or data
        send_word(fds_pkg::EV_START, '0, 32'hFFFF_FFFF);
        send_event(fds_pkg::EV_DONE);    // done during delay, dropped
        send_event(fds_pkg::EV_TICK);
        send_event(fds_pkg::EV_TICK);    // ping
        send_event(fds_pkg::EV_TICK);    // tick after delay, dropped
        repeat (3) send_event(fds_pkg::EV_DONE);

        // largest size the field holds: first two erases, then a restart mid-erase
        send_word(fds_pkg::EV_START, '1, 32'h0000_0000);
        repeat (2) send_event(fds_pkg::EV_TICK);
        repeat (2) send_event(fds_pkg::EV_DONE);
        // restart while busy; 129 bytes gives a full chunk and a clipped one-byte chunk
        send_word(fds_pkg::EV_START, fds_pkg::SIZE_W'(129), 32'h5A5A_A5A5);
        repeat (2) send_event(fds_pkg::EV_TICK);
        send_event(EV_UNUSED);
        repeat (6) send_event(fds_pkg::EV_DONE);

        // ---- random part, in phases with different startup delays ----
        phase_no = 0;
        while (sent_words < ITEM_TARGET)
        begin
            case (phase_no)
                0:       cfg = fds_pkg::DELAY_RESET;
                1:       cfg = '0;
                2:       cfg = '1;
                default: cfg = ($urandom_range(0, 9) == 0)
                             ? fds_pkg::DELAY_W'($urandom_range(13, 60))
                             : fds_pkg::DELAY_W'($urandom_range(0, 12));
            endcase
            set_startup_delay(cfg);
            steady = (phase_no % 4 == 3);
            // a long delay makes each run expensive: one short run is enough there
            n_seq = (cfg > 8'd100) ? 1 : $urandom_range(2, 5);
            for (seq = 0; seq < n_seq && sent_words < ITEM_TARGET; seq++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_event(2'($urandom_range(1, 3)));
                if (cfg > 8'd100)
                    run_download(fds_pkg::SIZE_W'($urandom_range(1, 300)), $urandom);
                else
                    run_download(pick_image_size(), $urandom);
            end
            phase_no++;
        end
        steady = 1'b0;

        // ---- wrap-up ----
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && cmds_pending == 0)
            $display("firmware_download_sequencer_top test passed");
        else
            $display("firmware_download_sequencer_top test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/fds_pkg.sv
hw/rtl/firmware_download_sequencer_top.sv
test/fds_command_checker.sv
test/tb_firmware_download_sequencer_top.sv
